// ===== rtl/core/recombination_electron_yield_core_defines.svh =====
// Assertion helpers for the checker file of this block.
`ifndef RECOMBINATION_ELECTRON_YIELD_CORE_DEFINES_SVH
`define RECOMBINATION_ELECTRON_YIELD_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the core clock, off during reset.
`define REY_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("port check failed");

// Next-cycle implication, sampled on the core clock, off during reset.
`define REY_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

// ===== rtl/core/rey_pkg.sv =====
package rey_pkg;

  // Log resolution: fraction bits of log2, one per squaring stage.
  localparam int LOG_TABLE_BITS = 10;

  // Field widths.
  localparam int E_W   = 24;
  localparam int L_W   = 24;
  localparam int CFG_W = 16;
  localparam int OUT_W = 24;

  // Datapath widths.
  localparam int DIV_W    = 56;                 // divider dividend, divisor, quotient
  localparam int D_W      = E_W + 16;           // dE/dx quotient, Q.16
  localparam int S_W      = DIV_W + 1;          // A*4 + Xi
  localparam int NORM_W   = 64;                 // normalizer word
  localparam int NORM_STG = $clog2(NORM_W);     // shift stages of the normalizer
  localparam int LZ_W     = NORM_STG;
  localparam int MANT_W   = 31;                 // mantissa, Q1.30
  localparam int IP_W     = 7;                  // signed integer part of log2
  localparam int L2U_W    = IP_W - 1 + LOG_TABLE_BITS;
  localparam int LN2_W    = 30;
  localparam int LNQ_W    = L2U_W + LN2_W;
  localparam int LN_SH    = 18 - LOG_TABLE_BITS;
  localparam int RQ_W     = LNQ_W + LN_SH;      // recombination factor, Q.32
  localparam int RQ_LO    = RQ_W / 2;
  localparam int RQ_HI    = RQ_W - RQ_LO;
  localparam int EP_W     = E_W + CFG_W;        // deposit times electrons per MeV
  localparam int PROD_W   = EP_W + RQ_W;
  localparam int RND_SH   = 48;

  localparam logic [LN2_W-1:0] LN2_Q30  = LN2_W'(744261118);
  localparam logic [D_W-1:0]   DEDX_MIN = D_W'(65536);
  localparam logic [RQ_W-1:0]  RQ_ONE   = RQ_W'(64'd1 << 32);
  localparam logic [IP_W-1:0]  IP_BIAS  = IP_W'(NORM_W - 1 - 16);

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] FIELD_RST = 16'd2048;
  localparam logic [CFG_W-1:0] ALPHA_RST = 16'd15237;
  localparam logic [CFG_W-1:0] BETA_RST  = 16'd3473;
  localparam logic [CFG_W-1:0] EPM_RST   = 16'd42370;

  // Register map, one word per register.
  typedef enum logic [1:0] {
    REG_FIELD = 2'd0,
    REG_ALPHA = 2'd1,
    REG_BETA  = 2'd2,
    REG_EPM   = 2'd3
  } rey_reg_e;

  // Sideband that travels with an item through the long units.
  typedef struct packed {
    logic [E_W-1:0]   e;
    logic [DIV_W-1:0] xi;
    logic             zero;   // result forced to zero
    logic             xi0;    // Xi is zero, no recombination
  } rey_side_t;

endpackage

// ===== rtl/core/recombination_electron_yield_core.sv =====
// Recombination-corrected electron yield, modified box model.
// Input channel: one beat carries energy_deposit_i and step_length_i (Q8.16).
// Output channel: one beat per input beat, num_electrons_o rounded and clipped
// to 24 bits, saturated_o set when clipped. Results leave in input order.
// Configuration: APB write of field, A, B and electrons per MeV at byte
// addresses 0, 4, 8 and 12; write only while no beat is in flight.
// Pipeline: three 56-stage bit-per-stage dividers, the 6-stage normalizer
// and one squaring stage per log2 fraction bit.
// Throughput: one beat per cycle, sustained while the output beat is taken.
// Stall: the whole pipeline holds while the output beat waits; in_ready_o
// stays high whenever the output register is empty or being taken, so a
// new beat enters in the same cycle that a result leaves.
// Reset: clears every valid bit and loads the register reset values;
// the block accepts beats in the first cycle after reset.
module recombination_electron_yield_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rey_pkg::E_W-1:0]       energy_deposit_i,
  input  logic [rey_pkg::L_W-1:0]       step_length_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rey_pkg::OUT_W-1:0]     num_electrons_o,
  output logic                          saturated_o
);
  import rey_pkg::*;

  logic en;

  // Configuration registers
  logic [CFG_W-1:0] field_q, alpha_q, beta_q, epm_q;
  logic [CFG_W-1:0] field_eff;
  rey_reg_e         reg_sel;

  // Stage registers
  logic             v0_q;
  logic [E_W-1:0]   e0_q;
  logic [L_W-1:0]   len0_q;
  rey_side_t        side0;

  logic             va_v;
  logic [DIV_W-1:0] qa;
  rey_side_t        sa;
  logic [D_W-1:0]   dedx, dedx_cl;

  logic             v1_q;
  logic [DIV_W-1:0] bd1_q;
  rey_side_t        s1_q;

  logic             vb_v;
  logic [DIV_W-1:0] qb;
  rey_side_t        sb;

  logic             v2_q;
  logic [S_W-1:0]   s2_q;
  rey_side_t        s2s_q;

  logic                      vl_v;
  logic [LZ_W-1:0]           lz;
  logic [LOG_TABLE_BITS-1:0] frac;
  rey_side_t                 sl;
  logic [IP_W-1:0]           ip;
  logic                      l2_pos;
  logic [L2U_W-1:0]          l2u;

  logic             v3_q;
  logic [LNQ_W-1:0] lnq3_q;
  rey_side_t        s3_q;

  logic             vc_v;
  logic [DIV_W-1:0] qc;
  rey_side_t        sc;

  logic             v4_q;
  logic [RQ_W-1:0]  rq4_q;
  logic [EP_W-1:0]  ep4_q;

  logic               v5_q;
  logic [EP_W+RQ_LO-1:0] pplo5_q;
  logic [EP_W+RQ_HI-1:0] pphi5_q;

  logic              v6_q;
  logic [PROD_W-1:0] sum6_q;

  logic                  out_vld_q;
  logic [OUT_W-1:0]      num_q;
  logic                  sat_q;
  logic [PROD_W-RND_SH-1:0] res;

  // Hold everything while the output beat is stalled.
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // Register writes and reads
  assign reg_sel = rey_reg_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q <= FIELD_RST;
      alpha_q <= ALPHA_RST;
      beta_q  <= BETA_RST;
      epm_q   <= EPM_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_FIELD: field_q <= pwdata[CFG_W-1:0];
        REG_ALPHA: alpha_q <= pwdata[CFG_W-1:0];
        REG_BETA:  beta_q  <= pwdata[CFG_W-1:0];
        REG_EPM:   epm_q   <= pwdata[CFG_W-1:0];
        default:   field_q <= field_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FIELD: prdata = 32'(field_q);
      REG_ALPHA: prdata = 32'(alpha_q);
      REG_BETA:  prdata = 32'(beta_q);
      REG_EPM:   prdata = 32'(epm_q);
      default:   prdata = '0;
    endcase
  end

  // Treat a zero field as the smallest field.
  assign field_eff = (field_q == '0) ? CFG_W'(1) : field_q;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e0_q   <= energy_deposit_i;
      len0_q <= step_length_i;
    end
  end

  assign side0 = '{e: e0_q, xi: '0, zero: (len0_q == '0), xi0: 1'b0};

  // dE/dx = deposit * 2^16 / length
  rey_div u_div_dedx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .num_i   (DIV_W'({e0_q, 16'b0})),
    .den_i   (DIV_W'(len0_q)),
    .side_i  (side0),
    .valid_o (va_v),
    .quot_o  (qa),
    .side_o  (sa)
  );

  // Clamp dE/dx to at least one, then scale by B.
  assign dedx    = qa[D_W-1:0];
  assign dedx_cl = (dedx < DEDX_MIN) ? DEDX_MIN : dedx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= va_v;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bd1_q <= beta_q * dedx_cl;
      s1_q  <= sa;
    end
  end

  // Xi = B * dEdx / (4 * field)
  rey_div u_div_xi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_q),
    .num_i   (bd1_q),
    .den_i   (DIV_W'({field_eff, 2'b00})),
    .side_i  (s1_q),
    .valid_o (vb_v),
    .quot_o  (qb),
    .side_o  (sb)
  );

  // S = 4A + Xi; keep Xi for the final divide.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= vb_v;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q  <= S_W'({alpha_q, 2'b00}) + S_W'(qb);
      s2s_q <= '{e: sb.e, xi: qb, zero: sb.zero, xi0: (qb == '0)};
    end
  end

  rey_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .s_i     (NORM_W'(s2_q)),
    .side_i  (s2s_q),
    .valid_o (vl_v),
    .lz_o    (lz),
    .frac_o  (frac),
    .side_o  (sl)
  );

  // Form log2 from the leading-one position and scale by ln2.
  assign ip     = IP_BIAS - IP_W'(lz);
  assign l2_pos = !ip[IP_W-1] && ((ip != '0) || (frac != '0));
  assign l2u    = {ip[IP_W-2:0], frac};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= vl_v;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lnq3_q <= l2u * LN2_Q30;
      s3_q   <= '{e: sl.e, xi: sl.xi, zero: sl.zero || (!sl.xi0 && !l2_pos), xi0: sl.xi0};
    end
  end

  // R = ln(S) / Xi, Q.32
  rey_div u_div_rq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (DIV_W'({lnq3_q, {LN_SH{1'b0}}})),
    .den_i   (s3_q.xi),
    .side_i  (s3_q),
    .valid_o (vc_v),
    .quot_o  (qc),
    .side_o  (sc)
  );

  // Pick R for the special cases and form deposit times yield.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= vc_v;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sc.zero)     rq4_q <= '0;
      else if (sc.xi0) rq4_q <= RQ_ONE;
      else             rq4_q <= qc[RQ_W-1:0];
      ep4_q <= sc.e * epm_q;
    end
  end

  // Partial products of the final multiply.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pplo5_q <= ep4_q * rq4_q[RQ_LO-1:0];
      pphi5_q <= ep4_q * rq4_q[RQ_W-1:RQ_LO];
    end
  end

  // Combine partial products and add the rounding half.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum6_q <= PROD_W'({pphi5_q, {RQ_LO{1'b0}}}) + PROD_W'(pplo5_q)
              + (PROD_W'(1) << (RND_SH - 1));
    end
  end

  // Round, clip and present the result.
  assign res = sum6_q[PROD_W-1:RND_SH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= v6_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sat_q <= |res[PROD_W-RND_SH-1:OUT_W];
      num_q <= (|res[PROD_W-RND_SH-1:OUT_W]) ? '1 : res[OUT_W-1:0];
    end
  end

  assign out_valid_o     = out_vld_q;
  assign num_electrons_o = num_q;
  assign saturated_o     = sat_q;

endmodule

// ===== rtl/core/rey_div.sv =====
module rey_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [rey_pkg::DIV_W-1:0]   num_i,
  input  logic [rey_pkg::DIV_W-1:0]   den_i,
  input  rey_pkg::rey_side_t          side_i,
  output logic                        valid_o,
  output logic [rey_pkg::DIV_W-1:0]   quot_o,
  output rey_pkg::rey_side_t          side_o
);
  import rey_pkg::*;

  // One restoring step: returns {quotient bit, new remainder}.
  function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                               input logic             nb,
                                               input logic [DIV_W-1:0] den);
    logic [DIV_W:0] t;
    t = {rem, nb};
    if (t >= {1'b0, den}) begin
      return {1'b1, DIV_W'(t - {1'b0, den})};
    end else begin
      return {1'b0, t[DIV_W-1:0]};
    end
  endfunction

  logic [DIV_W-1:0] rem_q [DIV_W-1];
  logic [DIV_W-1:0] rem_d [DIV_W-1];
  logic [DIV_W-1:0] num_q [DIV_W-1];
  logic [DIV_W-1:0] num_d [DIV_W-1];
  logic [DIV_W-1:0] den_q [DIV_W-1];
  logic [DIV_W-1:0] den_d [DIV_W-1];
  logic [DIV_W-1:0] quo_q [DIV_W];
  logic [DIV_W-1:0] quo_d [DIV_W];
  logic             vld_q [DIV_W];
  rey_side_t        side_q [DIV_W];

  // Compute one quotient bit per stage, most significant first.
  always_comb begin
    logic [DIV_W:0] st;
    st       = div_step('0, num_i[DIV_W-1], den_i);
    rem_d[0] = st[DIV_W-1:0];
    num_d[0] = {num_i[DIV_W-2:0], 1'b0};
    den_d[0] = den_i;
    quo_d[0] = {{(DIV_W-1){1'b0}}, st[DIV_W]};
    for (int k = 1; k < DIV_W - 1; k++) begin
      st       = div_step(rem_q[k-1], num_q[k-1][DIV_W-1], den_q[k-1]);
      rem_d[k] = st[DIV_W-1:0];
      num_d[k] = {num_q[k-1][DIV_W-2:0], 1'b0};
      den_d[k] = den_q[k-1];
      quo_d[k] = {quo_q[k-1][DIV_W-2:0], st[DIV_W]};
    end
    st = div_step(rem_q[DIV_W-2], num_q[DIV_W-2][DIV_W-1], den_q[DIV_W-2]);
    quo_d[DIV_W-1] = {quo_q[DIV_W-2][DIV_W-2:0], st[DIV_W]};
  end

  // Advance valid bits with the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_W; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < DIV_W; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // Advance the partial results and the sideband.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_W - 1; k++) begin
        rem_q[k] <= rem_d[k];
        num_q[k] <= num_d[k];
        den_q[k] <= den_d[k];
      end
      for (int k = 0; k < DIV_W; k++) quo_q[k] <= quo_d[k];
      side_q[0] <= side_i;
      for (int k = 1; k < DIV_W; k++) side_q[k] <= side_q[k-1];
    end
  end

  assign valid_o = vld_q[DIV_W-1];
  assign quot_o  = quo_q[DIV_W-1];
  assign side_o  = side_q[DIV_W-1];

endmodule

// ===== rtl/core/rey_log2.sv =====
module rey_log2 (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [rey_pkg::NORM_W-1:0]            s_i,
  input  rey_pkg::rey_side_t                    side_i,
  output logic                                  valid_o,
  output logic [rey_pkg::LZ_W-1:0]              lz_o,
  output logic [rey_pkg::LOG_TABLE_BITS-1:0]    frac_o,
  output rey_pkg::rey_side_t                    side_o
);
  import rey_pkg::*;

  localparam int LTB = LOG_TABLE_BITS;

  // Normalizer stages
  logic [NORM_W-1:0] nsrc   [NORM_STG];
  logic [LZ_W-1:0]   zsrc   [NORM_STG];
  logic [NORM_W-1:0] norm_q [NORM_STG];
  logic [NORM_W-1:0] norm_d [NORM_STG];
  logic [LZ_W-1:0]   lz_q   [NORM_STG];
  logic [LZ_W-1:0]   lz_d   [NORM_STG];
  logic              vn_q   [NORM_STG];
  rey_side_t         sn_q   [NORM_STG];

  // Squaring stages
  logic [MANT_W-1:0] msrc [LTB];
  logic [LTB-1:0]    bsrc [LTB];
  logic [MANT_W-1:0] m_q  [LTB];
  logic [MANT_W-1:0] m_d  [LTB];
  logic [LTB-1:0]    b_q  [LTB];
  logic [LTB-1:0]    b_d  [LTB];
  logic [LZ_W-1:0]   lzs_q [LTB];
  logic              vs_q [LTB];
  rey_side_t         ss_q [LTB];

  // Shift the leading one to the top, halving the shift each stage.
  always_comb begin
    int sh;
    nsrc[0] = s_i;
    zsrc[0] = '0;
    for (int j = 1; j < NORM_STG; j++) begin
      nsrc[j] = norm_q[j-1];
      zsrc[j] = lz_q[j-1];
    end
    for (int j = 0; j < NORM_STG; j++) begin
      sh = NORM_W >> (j + 1);
      if ((nsrc[j] >> (NORM_W - sh)) == '0) begin
        norm_d[j] = nsrc[j] << sh;
        lz_d[j]   = zsrc[j] | LZ_W'(sh);
      end else begin
        norm_d[j] = nsrc[j];
        lz_d[j]   = zsrc[j];
      end
    end
  end

  // Square the mantissa; each step yields one fraction bit of log2.
  always_comb begin
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     t;
    msrc[0] = norm_q[NORM_STG-1][NORM_W-1 -: MANT_W];
    bsrc[0] = '0;
    for (int i = 1; i < LTB; i++) begin
      msrc[i] = m_q[i-1];
      bsrc[i] = b_q[i-1];
    end
    for (int i = 0; i < LTB; i++) begin
      sq = msrc[i] * msrc[i];
      t  = sq[2*MANT_W-1 -: MANT_W+1];
      if (t[MANT_W]) begin
        m_d[i] = t[MANT_W:1];
        b_d[i] = {bsrc[i][LTB-2:0], 1'b1};
      end else begin
        m_d[i] = t[MANT_W-1:0];
        b_d[i] = {bsrc[i][LTB-2:0], 1'b0};
      end
    end
  end

  // Advance valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NORM_STG; j++) vn_q[j] <= 1'b0;
      for (int i = 0; i < LTB; i++) vs_q[i] <= 1'b0;
    end else if (en_i) begin
      vn_q[0] <= valid_i;
      for (int j = 1; j < NORM_STG; j++) vn_q[j] <= vn_q[j-1];
      vs_q[0] <= vn_q[NORM_STG-1];
      for (int i = 1; i < LTB; i++) vs_q[i] <= vs_q[i-1];
    end
  end

  // Advance payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NORM_STG; j++) begin
        norm_q[j] <= norm_d[j];
        lz_q[j]   <= lz_d[j];
      end
      sn_q[0] <= side_i;
      for (int j = 1; j < NORM_STG; j++) sn_q[j] <= sn_q[j-1];
      for (int i = 0; i < LTB; i++) begin
        m_q[i] <= m_d[i];
        b_q[i] <= b_d[i];
      end
      lzs_q[0] <= lz_q[NORM_STG-1];
      ss_q[0]  <= sn_q[NORM_STG-1];
      for (int i = 1; i < LTB; i++) begin
        lzs_q[i] <= lzs_q[i-1];
        ss_q[i]  <= ss_q[i-1];
      end
    end
  end

  assign valid_o = vs_q[LTB-1];
  assign lz_o    = lzs_q[LTB-1];
  assign frac_o  = b_q[LTB-1];
  assign side_o  = ss_q[LTB-1];

endmodule

// ===== rtl/core/rey_checker.sv =====
`include "recombination_electron_yield_core_defines.svh"

module rey_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [23:0] num_electrons_o,
  input logic        saturated_o
);

  // Hold a stalled output beat.
  `REY_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `REY_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i, $stable({num_electrons_o, saturated_o}))

  // Clip to the full-scale count when saturated.
  `REY_ASSERT_IMP(a_sat_max, out_valid_o && saturated_o, num_electrons_o == 24'hFFFFFF)

  // Take input whenever the output slot frees, block it otherwise.
  `REY_ASSERT_IMP(a_ready_free, !out_valid_o || out_ready_i, in_ready_o)
  `REY_ASSERT_IMP(a_ready_stall, out_valid_o && !out_ready_i, !in_ready_o)

endmodule

bind recombination_electron_yield_core rey_checker u_rey_checker (.*);

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rey_pkg::*;

  typedef struct {
    logic [E_W-1:0] deposit;
    logic [L_W-1:0] length;
  } step_t;

  typedef struct {
    logic [OUT_W-1:0] count;
    logic             clip;
  } yield_t;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 250;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [E_W-1:0] energy_deposit_i = '0;
  logic [L_W-1:0] step_length_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [OUT_W-1:0] num_electrons_o;
  logic saturated_o;

  // Shadow copy of the configuration registers
  logic [CFG_W-1:0] field_q = FIELD_RST;
  logic [CFG_W-1:0] alpha_q = ALPHA_RST;
  logic [CFG_W-1:0] beta_q  = BETA_RST;
  logic [CFG_W-1:0] epm_q   = EPM_RST;

  step_t  pending_steps[$];
  yield_t expected_yields[$];
  int     errors = 0;
  int     cycles = 0;
  bit     steady = 1'b0;     // no idling on either side
  int     hold_req = 0;
  int     hold_seen = 0;
  int     hold_left = 0;
  int     send_gap = 0;
  int     recv_gap = 0;
  bit     in_beat_q = 1'b0;

  recombination_electron_yield_core uut (.*);

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Surviving electron count for one step under the current registers
  function automatic yield_t electron_yield(logic [E_W-1:0] dep, logic [L_W-1:0] len);
    yield_t y;
    logic [63:0] dedx, fld, xi, s, m, lnq, rq;
    logic [127:0] prod;
    longint l2;
    int p;
    y.count = '0;
    y.clip = 1'b0;
    if (len == 0) return y;
    dedx = (64'(dep) << 16) / 64'(len);
    if (dedx < 64'd65536) dedx = 64'd65536;
    fld = (field_q == 0) ? 64'd1 : 64'(field_q);
    xi = (64'(beta_q) * dedx) / (64'd4 * fld);
    if (xi == 0) begin
      rq = 64'd1 << 32;
    end else begin
      s = 64'(alpha_q) * 4 + xi;
      p = 63;
      while (p > 0 && !s[p]) p--;
      m = (p >= 30) ? (s >> (p - 30)) : (s << (30 - p));
      l2 = p - 16;
      // One fraction bit of log2 per squaring
      for (int k = 0; k < LOG_TABLE_BITS; k++) begin
        m = (m * m) >> 30;
        l2 = l2 * 2;
        if (m >= 64'h8000_0000) begin
          m = m >> 1;
          l2 = l2 + 1;
        end
      end
      if (l2 <= 0) return y;
      lnq = 64'(l2) * 64'(LN2_Q30);
      rq = (lnq << (18 - LOG_TABLE_BITS)) / xi;
    end
    prod = 128'(64'(dep) * 64'(epm_q)) * 128'(rq);
    prod = (prod + (128'd1 << 47)) >> 48;
    if (prod > 128'hFF_FFFF) begin
      y.count = '1;
      y.clip = 1'b1;
    end else begin
      y.count = prod[OUT_W-1:0];
    end
    return y;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Drive input beats from the pending queue
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_beat_q) begin
        // hold until taken
      end else if (send_gap > 0 && !steady) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_steps.size() > 0) begin
        step_t st;
        st = pending_steps.pop_front();
        in_valid_i <= 1'b1;
        energy_deposit_i <= st.deposit;
        step_length_i <= st.length;
        send_gap <= gap_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output ready with random stalls and one long hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= 400;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0 && !steady) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        recv_gap <= gap_len();
      end
    end
  end

  // Predict on accepted input, check on accepted output
  always @(posedge clk_i) begin
    in_beat_q <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o)
      expected_yields.push_back(electron_yield(energy_deposit_i, step_length_i));
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_yields.size() == 0) begin
        $display("unexpected result beat at %0t", $realtime);
        errors++;
      end else begin
        yield_t y;
        y = expected_yields.pop_front();
        if (num_electrons_o !== y.count)
          report_mismatch("num_electrons", 32'(num_electrons_o), 32'(y.count));
        if (saturated_o !== y.clip)
          report_mismatch("saturated", 32'(saturated_o), 32'(y.clip));
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic reg_write(rey_reg_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= 32'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_FIELD: field_q = val;
      REG_ALPHA: alpha_q = val;
      REG_BETA:  beta_q = val;
      default:   epm_q = val;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_regs(logic [CFG_W-1:0] f, logic [CFG_W-1:0] a,
                          logic [CFG_W-1:0] b, logic [CFG_W-1:0] n);
    reg_write(REG_FIELD, f);
    reg_write(REG_ALPHA, a);
    reg_write(REG_BETA, b);
    reg_write(REG_EPM, n);
  endtask

  task automatic push_step(logic [E_W-1:0] d, logic [L_W-1:0] l);
    step_t st;
    st.deposit = d;
    st.length = l;
    pending_steps.push_back(st);
  endtask

  // Random steps with a spread of dE/dx
  task automatic push_random(int n);
    logic [E_W-1:0] d;
    logic [L_W-1:0] l;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: begin d = E_W'($urandom()); l = L_W'($urandom()); end
        1: begin
          d = E_W'($urandom_range(0, 65535 * 4));
          l = L_W'($urandom_range(1, 65536 * 2));
        end
        2: begin d = E_W'($urandom()); l = L_W'($urandom_range(0, 255)); end
        3: begin d = E_W'($urandom_range(0, 4095)); l = L_W'($urandom()); end
        default: begin
          d = $urandom_range(0, 1) ? '1 : E_W'($urandom());
          l = L_W'($urandom_range(0, 3));
        end
      endcase
      push_step(d, l);
    end
  endtask

  task automatic drain();
    while (pending_steps.size() > 0 || in_valid_i || expected_yields.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed steps at reset settings
    push_step('0, '0);
    push_step('1, '0);
    push_step('0, 24'd65536);
    push_step('1, '1);
    push_step('1, 24'd1);
    push_step(24'd1, '1);
    push_step(24'd65536, 24'd65536);
    push_step(24'd65536 * 2, 24'd65536);
    push_step(24'h55_5555, 24'hAA_AAAA);
    push_step(24'hAA_AAAA, 24'h55_5555);
    push_step(24'd1, 24'd1);
    drain();

    // No recombination with zero B, at the largest electrons per MeV
    set_regs(16'd1, 16'd0, 16'd0, 16'hFFFF);
    push_step('1, '1);
    push_step('1, 24'd1);
    push_step(24'd300, 24'd65536);
    push_step(24'd0, 24'd5);
    drain();

    // 4A + Xi of one or less gives zero; zero field treated as one
    set_regs(16'd0, 16'd0, 16'd1, 16'd1000);
    push_step(24'd65536, 24'd65536);
    push_step('1, 24'd1);
    push_step(24'd100, '1);
    drain();

    // Full-scale registers with random steps, long output hold-off
    set_regs('1, '1, '1, '1);
    hold_req++;
    push_random(200);
    drain();

    set_regs(16'd1, 16'd0, 16'd0, 16'd0);
    push_random(60);
    drain();

    // Back-to-back beats, no idling
    steady = 1'b1;
    set_regs(FIELD_RST, ALPHA_RST, BETA_RST, EPM_RST);
    push_random(150);
    drain();
    steady = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      set_regs(CFG_W'($urandom_range(1, 65535)), CFG_W'($urandom()),
               CFG_W'($urandom()), CFG_W'($urandom()));
      push_random(110);
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
